// ----- sv/sgi_pkg.sv -----
// Shared types and constants for the segment intersection pipeline.
`default_nettype none
package sgi_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CROSS_EPSILON     = 2'd0,
    REG_GRAZE_DIST_SQ     = 2'd1,
    REG_DEGENERATE_LEN_SQ = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_PROPER = 2'd1,
    HIT_GRAZE  = 2'd2
  } hit_kind_t;

  typedef logic signed [16:0] diff_t;

  // Coordinate differences: segment vectors and the four cross-segment offsets.
  typedef struct packed {
    diff_t vax, vay, vbx, vby;
    diff_t e11x, e11y, e21x, e21y, e12x, e12y, e22x, e22y;
  } s1_t;

  // Raw products: cross terms, dot terms and squares.
  typedef struct packed {
    logic [7:0][33:0]  cp;
    logic [7:0][33:0]  dp;
    logic [11:0][31:0] sq;
  } s2_t;

  // Orientations, dot products and squared lengths, one lane per endpoint.
  typedef struct packed {
    logic [3:0][34:0] d;
    logic [3:0][34:0] dot;
    logic [32:0]      len_a, len_b, n11, n21, n12, n22;
  } s3_t;

  // Per-endpoint decisions ahead of the final square.
  typedef struct packed {
    logic             kind1;
    logic             opp;
    logic [3:0]       interior;
    logic [3:0]       simple;
    logic [3:0]       big;
    logic [3:0][24:0] mag;
    logic [3:0][48:0] gl;
  } s4_t;

endpackage
`default_nettype wire

// ----- sv/sgi_diff.sv -----
// Input stage: coordinate differences.
`default_nettype none
module sgi_diff
  import sgi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic signed [15:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y,
  output s1_t                     s1,
  output logic                    v1
);

  function automatic diff_t sub(input logic signed [15:0] p, input logic signed [15:0] q);
    return {p[15], p} - {q[15], q};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.vax  <= sub(a2x, a1x);
      s1.vay  <= sub(a2y, a1y);
      s1.vbx  <= sub(b2x, b1x);
      s1.vby  <= sub(b2y, b1y);
      s1.e11x <= sub(a1x, b1x);
      s1.e11y <= sub(a1y, b1y);
      s1.e21x <= sub(a2x, b1x);
      s1.e21y <= sub(a2y, b1y);
      s1.e12x <= sub(a1x, b2x);
      s1.e12y <= sub(a1y, b2y);
      s1.e22x <= sub(a2x, b2x);
      s1.e22y <= sub(a2y, b2y);
    end
  end

endmodule
`default_nettype wire

// ----- sv/sgi_prod.sv -----
// Product stage and sum stage: orientations, dot products, squared lengths.
`default_nettype none
module sgi_prod
  import sgi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic v1,
  input  wire s1_t  s1,
  output s3_t       s3,
  output logic      v3
);

  s2_t  s2;
  logic v2;

  function automatic logic [33:0] mul(input diff_t p, input diff_t q);
    return p * q;
  endfunction

  // A square of a 17-bit difference never exceeds 32 bits.
  function automatic logic [31:0] sqr(input diff_t p);
    logic [33:0] t;
    t = p * p;
    return t[31:0];
  endfunction

  function automatic logic [34:0] sx(input logic [33:0] p);
    return {p[33], p};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.cp[0] <= mul(s1.vbx, s1.e11y);
      s2.cp[1] <= mul(s1.vby, s1.e11x);
      s2.cp[2] <= mul(s1.vbx, s1.e21y);
      s2.cp[3] <= mul(s1.vby, s1.e21x);
      s2.cp[4] <= mul(s1.vax, s1.e11y);
      s2.cp[5] <= mul(s1.vay, s1.e11x);
      s2.cp[6] <= mul(s1.vax, s1.e12y);
      s2.cp[7] <= mul(s1.vay, s1.e12x);
      s2.dp[0] <= mul(s1.e11x, s1.vbx);
      s2.dp[1] <= mul(s1.e11y, s1.vby);
      s2.dp[2] <= mul(s1.e21x, s1.vbx);
      s2.dp[3] <= mul(s1.e21y, s1.vby);
      s2.dp[4] <= mul(s1.e11x, s1.vax);
      s2.dp[5] <= mul(s1.e11y, s1.vay);
      s2.dp[6] <= mul(s1.e12x, s1.vax);
      s2.dp[7] <= mul(s1.e12y, s1.vay);
      s2.sq[0]  <= sqr(s1.vax);
      s2.sq[1]  <= sqr(s1.vay);
      s2.sq[2]  <= sqr(s1.vbx);
      s2.sq[3]  <= sqr(s1.vby);
      s2.sq[4]  <= sqr(s1.e11x);
      s2.sq[5]  <= sqr(s1.e11y);
      s2.sq[6]  <= sqr(s1.e21x);
      s2.sq[7]  <= sqr(s1.e21y);
      s2.sq[8]  <= sqr(s1.e12x);
      s2.sq[9]  <= sqr(s1.e12y);
      s2.sq[10] <= sqr(s1.e22x);
      s2.sq[11] <= sqr(s1.e22y);
    end
  end

  // The second segment's endpoints see segment A from the other side: negate.
  always_ff @(posedge clk) begin
    if (en) begin
      s3.d[0]   <= sx(s2.cp[0]) - sx(s2.cp[1]);
      s3.d[1]   <= sx(s2.cp[2]) - sx(s2.cp[3]);
      s3.d[2]   <= sx(s2.cp[5]) - sx(s2.cp[4]);
      s3.d[3]   <= sx(s2.cp[7]) - sx(s2.cp[6]);
      s3.dot[0] <= sx(s2.dp[0]) + sx(s2.dp[1]);
      s3.dot[1] <= sx(s2.dp[2]) + sx(s2.dp[3]);
      s3.dot[2] <= 35'd0 - sx(s2.dp[4]) - sx(s2.dp[5]);
      s3.dot[3] <= 35'd0 - sx(s2.dp[6]) - sx(s2.dp[7]);
      s3.len_a  <= {1'b0, s2.sq[0]} + {1'b0, s2.sq[1]};
      s3.len_b  <= {1'b0, s2.sq[2]} + {1'b0, s2.sq[3]};
      s3.n11    <= {1'b0, s2.sq[4]} + {1'b0, s2.sq[5]};
      s3.n21    <= {1'b0, s2.sq[6]} + {1'b0, s2.sq[7]};
      s3.n12    <= {1'b0, s2.sq[8]} + {1'b0, s2.sq[9]};
      s3.n22    <= {1'b0, s2.sq[10]} + {1'b0, s2.sq[11]};
    end
  end

endmodule
`default_nettype wire

// ----- sv/sgi_near.sv -----
// Classification stage and graze distance stage, ending in the result register.
`default_nettype none
module sgi_near
  import sgi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        v3,
  input  wire s3_t         s3,
  input  wire logic [15:0] cross_epsilon,
  input  wire logic [15:0] graze_dist_sq,
  input  wire logic [15:0] degenerate_len_sq,
  output logic [1:0]       hit_kind,
  output logic             v5
);

  s4_t  s4, s4_next;
  logic v4;
  logic [3:0] near;

  function automatic logic apart(input logic signed [34:0] p, input logic signed [34:0] q,
                                 input logic [15:0] e);
    logic signed [34:0] es;
    es = $signed({19'd0, e});
    return (p > es && q < -es) || (p < -es && q > es);
  endfunction

  function automatic logic opposite(input logic signed [34:0] p, input logic signed [34:0] q);
    return (p > 0 && q < 0) || (p < 0 && q > 0);
  endfunction

  always_comb begin
    logic [3:0][32:0] nw, ne;
    logic [32:0]        lenp;
    logic signed [34:0] dotv, dv;
    logic [34:0]        magv;
    logic               pre, post;
    nw[0] = s3.n11; nw[1] = s3.n21; nw[2] = s3.n11; nw[3] = s3.n12;
    ne[0] = s3.n12; ne[1] = s3.n22; ne[2] = s3.n21; ne[3] = s3.n22;
    s4_next.kind1 = apart(s3.d[0], s3.d[1], cross_epsilon) &&
                    apart(s3.d[2], s3.d[3], cross_epsilon);
    s4_next.opp   = opposite(s3.d[0], s3.d[1]) && opposite(s3.d[2], s3.d[3]);
    for (int i = 0; i < 4; i++) begin
      lenp = (i < 2) ? s3.len_b : s3.len_a;
      dotv = $signed(s3.dot[i]);
      dv   = $signed(s3.d[i]);
      // Degenerate segment or projection before start: distance to start.
      pre  = (lenp < {17'd0, degenerate_len_sq}) || (dotv <= 0);
      post = dotv >= $signed({2'b00, lenp});
      s4_next.interior[i] = !pre && !post;
      s4_next.simple[i]   = pre ? (nw[i] < {17'd0, graze_dist_sq})
                                : (ne[i] < {17'd0, graze_dist_sq});
      magv = dv[34] ? 35'(-dv) : 35'(dv);
      // Any magnitude from 2^25 up squares beyond the largest threshold.
      s4_next.big[i] = |magv[34:25];
      s4_next.mag[i] = magv[24:0];
      s4_next.gl[i]  = 49'(graze_dist_sq) * 49'(lenp);
    end
  end

  always_comb begin
    logic [49:0] sqv;
    for (int i = 0; i < 4; i++) begin
      sqv     = 50'(s4.mag[i]) * 50'(s4.mag[i]);
      near[i] = s4.interior[i] ? (!s4.big[i] && sqv < {1'b0, s4.gl[i]}) : s4.simple[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= s4_next;
      if (s4.kind1) begin
        hit_kind <= HIT_PROPER;
      end else if (s4.opp && |near) begin
        hit_kind <= HIT_GRAZE;
      end else begin
        hit_kind <= HIT_NONE;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/segment_intersection_with_graze.sv -----
// Top level of the segment pair intersection test with graze detection.
// Tests two segments given as signed Q12.4 endpoints and reports no hit, a
// proper crossing, or a graze near an endpoint. One segment pair is taken
// every clock cycle while the pipeline advances; the result is registered
// through the difference, product, sum, classification and distance stages
// (the last one being the output register). The pipeline advances as a whole
// whenever the output register is empty or its result is being taken, so
// in_ready follows out_ready through one gate. Configuration registers reset to
// cross_epsilon 3, graze_dist_sq 256, degenerate_len_sq 1 and must be written
// only while no item is in flight.
`default_nettype none
module segment_intersection_with_graze
  import sgi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] first_start_x,
  input  wire logic signed [15:0] first_start_y,
  input  wire logic signed [15:0] first_end_x,
  input  wire logic signed [15:0] first_end_y,
  input  wire logic signed [15:0] second_start_x,
  input  wire logic signed [15:0] second_start_y,
  input  wire logic signed [15:0] second_end_x,
  input  wire logic signed [15:0] second_end_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              hit_kind
);

  logic [15:0] cross_epsilon, graze_dist_sq, degenerate_len_sq;
  logic        adv, v1, v3, v5;
  s1_t         s1;
  s3_t         s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_epsilon     <= 16'd3;
      graze_dist_sq     <= 16'd256;
      degenerate_len_sq <= 16'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CROSS_EPSILON:     cross_epsilon     <= cfg_data;
        REG_GRAZE_DIST_SQ:     graze_dist_sq     <= cfg_data;
        REG_DEGENERATE_LEN_SQ: degenerate_len_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance every stage together; hold all while the result waits.
  assign adv       = !v5 || out_ready;
  assign in_ready  = adv;
  assign out_valid = v5;

  sgi_diff u_diff (
    .clk (clk), .rst (rst), .en (adv), .in_v (in_valid),
    .a1x (first_start_x), .a1y (first_start_y),
    .a2x (first_end_x),   .a2y (first_end_y),
    .b1x (second_start_x), .b1y (second_start_y),
    .b2x (second_end_x),   .b2y (second_end_y),
    .s1 (s1), .v1 (v1)
  );

  sgi_prod u_prod (
    .clk (clk), .rst (rst), .en (adv), .v1 (v1), .s1 (s1), .s3 (s3), .v3 (v3)
  );

  sgi_near u_near (
    .clk (clk), .rst (rst), .en (adv), .v3 (v3), .s3 (s3),
    .cross_epsilon (cross_epsilon), .graze_dist_sq (graze_dist_sq),
    .degenerate_len_sq (degenerate_len_sq),
    .hit_kind (hit_kind), .v5 (v5)
  );

endmodule
`default_nettype wire
